/* sv/vrns_pkg.sv */
// Shared types and constants for the voxel ray next-cell step block.
package vrns_pkg;

	localparam int BIAS_W = 16;
	localparam logic [BIAS_W-1:0] BIAS_RESET = 16'd655;
	localparam int REG_STEP_BIAS = 0;

	// Biased point width and the wide width used for planes and crossings.
	localparam int PW = 33;
	localparam int HW = 34;

	typedef enum logic [1:0] {
		AXIS_X    = 2'd0,
		AXIS_Y    = 2'd1,
		AXIS_Z    = 2'd2,
		AXIS_NONE = 2'd3
	} axis_t;

	typedef logic signed [PW-1:0] pnt_t;

	// One classified item: biased point, direction and the winning axis.
	typedef struct packed {
		logic [2:0][PW-1:0] p;
		logic [2:0][31:0]   d;
		axis_t              axis;
	} step_t;

	typedef struct packed {
		logic  valid;
		step_t item;
	} push_t;

endpackage

/* sv/vrns_front.sv */
// Front part: applies the bias, finds plane distances and picks the crossed axis.
module vrns_front #(
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  logic signed [31:0]   pos_x,
	input  logic signed [31:0]   pos_y,
	input  logic signed [31:0]   pos_z,
	input  logic signed [31:0]   dir_x,
	input  logic signed [31:0]   dir_y,
	input  logic signed [31:0]   dir_z,
	input  logic [vrns_pkg::BIAS_W-1:0] step_bias,
	output vrns_pkg::push_t      push,
	input  logic                 push_full
);

	localparam int PW = vrns_pkg::PW;
	localparam int HW = vrns_pkg::HW;
	localparam int TW = FRAC_BITS + 1;
	localparam int NW = FRAC_BITS + 33;
	localparam int BW = vrns_pkg::BIAS_W;

	logic en;

	logic signed [31:0] pos_in [3];
	logic signed [31:0] dir_in [3];
	logic signed [BW+32:0] bprod [3];

	logic v_s1;
	logic signed [31:0] pos_s1 [3];
	logic signed [31:0] dir_s1 [3];
	logic signed [31:0] bofs_s1 [3];

	logic signed [PW-1:0] p2 [3];
	logic signed [HW-1:0] fl2 [3];
	logic signed [HW-1:0] pl2 [3];
	logic signed [HW-1:0] t2 [3];
	logic [TW-1:0] tm2 [3];
	logic [31:0] dm2 [3];

	logic v_s2;
	vrns_pkg::pnt_t p_s2 [3];
	logic signed [31:0] d_s2 [3];
	logic [TW-1:0] tm_s2 [3];
	logic [31:0] dm_s2 [3];

	logic v_s3;
	vrns_pkg::pnt_t p_s3 [3];
	logic signed [31:0] d_s3 [3];
	logic [NW-1:0] mab_s3 [3];
	logic [NW-1:0] mba_s3 [3];

	vrns_pkg::axis_t best3;

	logic v_s4;
	vrns_pkg::step_t item_s4;

	// The whole front holds only when a finished item cannot enter the queue.
	assign en = !v_s4 || !push_full;
	assign req_stall = !en;

	assign pos_in[0] = pos_x;
	assign pos_in[1] = pos_y;
	assign pos_in[2] = pos_z;
	assign dir_in[0] = dir_x;
	assign dir_in[1] = dir_y;
	assign dir_in[2] = dir_z;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			bprod[i] = (BW+33)'(dir_in[i]) * (BW+33)'($signed({1'b0, step_bias}));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= req_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			p2[i] = PW'(pos_s1[i]) + PW'(bofs_s1[i]);
			fl2[i] = HW'(p2[i]) >>> FRAC_BITS;
			pl2[i] = fl2[i] + ((dir_s1[i] > 32'sd0) ? HW'(1) : HW'(0));
			t2[i] = (pl2[i] <<< FRAC_BITS) - HW'(p2[i]);
			tm2[i] = t2[i][HW-1] ? TW'(-t2[i]) : TW'(t2[i]);
			dm2[i] = dir_s1[i][31] ? 32'(-dir_s1[i]) : 32'(dir_s1[i]);
		end
	end

	// Least ray parameter wins; a later axis must be strictly better to take over.
	always_comb begin
		best3 = vrns_pkg::AXIS_NONE;
		if (d_s3[0] != 32'sd0) begin
			best3 = vrns_pkg::AXIS_X;
		end
		if (d_s3[1] != 32'sd0) begin
			if (best3 == vrns_pkg::AXIS_NONE || mab_s3[0] > mba_s3[0]) begin
				best3 = vrns_pkg::AXIS_Y;
			end
		end
		if (d_s3[2] != 32'sd0) begin
			case (best3)
				vrns_pkg::AXIS_X: begin
					if (mab_s3[1] > mba_s3[1]) best3 = vrns_pkg::AXIS_Z;
				end
				vrns_pkg::AXIS_Y: begin
					if (mab_s3[2] > mba_s3[2]) best3 = vrns_pkg::AXIS_Z;
				end
				default: best3 = vrns_pkg::AXIS_Z;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				pos_s1[i] <= pos_in[i];
				dir_s1[i] <= dir_in[i];
				bofs_s1[i] <= bprod[i][BW+31:BW];
				p_s2[i] <= p2[i];
				d_s2[i] <= dir_s1[i];
				tm_s2[i] <= tm2[i];
				dm_s2[i] <= dm2[i];
				p_s3[i] <= p_s2[i];
				d_s3[i] <= d_s2[i];
				item_s4.p[i] <= p_s3[i];
				item_s4.d[i] <= d_s3[i];
			end
			// Pairs xy, xz, yz: |t_a|*|d_b| and |t_b|*|d_a|.
			mab_s3[0] <= NW'(tm_s2[0]) * NW'(dm_s2[1]);
			mba_s3[0] <= NW'(tm_s2[1]) * NW'(dm_s2[0]);
			mab_s3[1] <= NW'(tm_s2[0]) * NW'(dm_s2[2]);
			mba_s3[1] <= NW'(tm_s2[2]) * NW'(dm_s2[0]);
			mab_s3[2] <= NW'(tm_s2[1]) * NW'(dm_s2[2]);
			mba_s3[2] <= NW'(tm_s2[2]) * NW'(dm_s2[1]);
			item_s4.axis <= best3;
		end
	end

	assign push.valid = v_s4;
	assign push.item  = item_s4;

endmodule

/* sv/vrns_queue.sv */
// Short queue between the front and back parts.
module vrns_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  vrns_pkg::push_t push,
	output logic            full,
	input  logic            pop,
	output logic            head_valid,
	output vrns_pkg::step_t head
);

	localparam int DEPTH = 4;
	localparam int AW = $clog2(DEPTH);

	vrns_pkg::step_t mem_q [DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [AW:0]   cnt_q;
	logic do_push;
	logic do_pop;

	assign full       = (cnt_q == (AW+1)'(DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rd_q];
	assign do_push    = push.valid && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= wr_q + 1'b1;
			if (do_pop)  rd_q <= rd_q + 1'b1;
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= push.item;
	end

endmodule

/* sv/vrns_back.sv */
// Back part: pipelined division for the off-axis crossings, then result assembly.
module vrns_back #(
	parameter int FRAC_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   head_valid,
	input  vrns_pkg::step_t        head,
	output logic                   pop,
	output logic                   rsp_valid,
	input  logic                   rsp_stall,
	output logic signed [15:0]     voxel_x,
	output logic signed [15:0]     voxel_y,
	output logic signed [15:0]     voxel_z,
	output logic signed [31:0]     hit_x,
	output logic signed [31:0]     hit_y,
	output logic signed [31:0]     hit_z,
	output logic [1:0]             crossed_axis
);

	localparam int PW = vrns_pkg::PW;
	localparam int HW = vrns_pkg::HW;
	localparam int TW = FRAC_BITS + 1;
	localparam int NW = FRAC_BITS + 33;
	localparam int NS = FRAC_BITS + 1;

	function automatic logic signed [31:0] sat32(input logic signed [HW-1:0] v);
		logic [HW-32:0] top;
		top = v[HW-1:31];
		if (&top || ~|top) return v[31:0];
		return v[HW-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [HW-1:0] v);
		logic [HW-16:0] top;
		top = v[HW-1:15];
		if (&top || ~|top) return v[15:0];
		return v[HW-1] ? 16'sh8000 : 16'sh7FFF;
	endfunction

	logic en;

	// Stage 1: planes and the winning axis's distance, recomputed from the point.
	vrns_pkg::pnt_t     p1 [3];
	logic signed [HW-1:0] fl1 [3];
	logic signed [HW-1:0] pl1 [3];
	logic [31:0]        dm1 [3];
	logic [1:0]         bi1;
	logic signed [HW-1:0] tb1;

	logic               v_s1;
	vrns_pkg::axis_t    ax_s1;
	vrns_pkg::pnt_t     p_s1 [3];
	logic signed [HW-1:0] pl_s1 [3];
	logic [2:0]         negd_s1;
	logic [31:0]        dm_s1 [3];
	logic [TW-1:0]      tm_s1;
	logic               tneg_s1;
	logic [1:0]         bi_s1;

	// Divider pipeline; index 0 holds the products, index NS the finished quotients.
	logic               v_s    [NS+1];
	vrns_pkg::axis_t    ax_s   [NS+1];
	logic [2:0]         negd_s [NS+1];
	logic [2:0]         qneg_s [NS+1];
	vrns_pkg::pnt_t     p_s    [NS+1][3];
	logic signed [HW-1:0] pl_s [NS+1][3];
	logic [NW-1:0]      rem_s  [NS+1][3];
	logic [TW-1:0]      quo_s  [NS+1][3];
	logic [31:0]        dv_s   [NS+1];

	logic signed [HW-1:0] qv   [3];
	logic signed [HW-1:0] hw   [3];
	logic signed [HW-1:0] vw   [3];
	logic signed [31:0]   hit_o [3];
	logic signed [15:0]   vox_o [3];

	assign en  = !rsp_valid || !rsp_stall;
	assign pop = en && head_valid;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			p1[i]  = $signed(head.p[i]);
			fl1[i] = HW'(p1[i]) >>> FRAC_BITS;
			pl1[i] = fl1[i] + (($signed(head.d[i]) > 32'sd0) ? HW'(1) : HW'(0));
			dm1[i] = head.d[i][31] ? 32'(-head.d[i]) : head.d[i];
		end
		bi1 = (head.axis == vrns_pkg::AXIS_NONE) ? 2'd0 : head.axis;
		tb1 = (pl1[bi1] <<< FRAC_BITS) - HW'(p1[bi1]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s[0] <= 1'b0;
			rsp_valid <= 1'b0;
		end else if (en) begin
			v_s1 <= head_valid;
			v_s[0] <= v_s1;
			rsp_valid <= v_s[NS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1   <= head.axis;
			bi_s1   <= bi1;
			tm_s1   <= tb1[HW-1] ? TW'(-tb1) : TW'(tb1);
			tneg_s1 <= tb1[HW-1];
			for (int i = 0; i < 3; i++) begin
				p_s1[i]    <= p1[i];
				pl_s1[i]   <= pl1[i];
				negd_s1[i] <= head.d[i][31];
				dm_s1[i]   <= dm1[i];
			end
			ax_s[0]   <= ax_s1;
			negd_s[0] <= negd_s1;
			dv_s[0]   <= dm_s1[bi_s1];
			for (int i = 0; i < 3; i++) begin
				p_s[0][i]   <= p_s1[i];
				pl_s[0][i]  <= pl_s1[i];
				rem_s[0][i] <= NW'(dm_s1[i]) * NW'(tm_s1);
				quo_s[0][i] <= '0;
				// Quotient sign: sign(d_b) ^ sign(t_best) ^ sign(d_best).
				qneg_s[0][i] <= negd_s1[i] ^ tneg_s1 ^ negd_s1[bi_s1];
			end
		end
	end

	for (genvar k = 1; k <= NS; k++) begin : g_div
		localparam int J = NS - k;
		logic [NW-1:0] sh;
		assign sh = NW'(dv_s[k-1]) << J;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ax_s[k]   <= ax_s[k-1];
				negd_s[k] <= negd_s[k-1];
				qneg_s[k] <= qneg_s[k-1];
				dv_s[k]   <= dv_s[k-1];
				for (int i = 0; i < 3; i++) begin
					p_s[k][i]  <= p_s[k-1][i];
					pl_s[k][i] <= pl_s[k-1][i];
					if (rem_s[k-1][i] >= sh) begin
						rem_s[k][i] <= rem_s[k-1][i] - sh;
						quo_s[k][i] <= quo_s[k-1][i] | (TW'(1) << J);
					end else begin
						rem_s[k][i] <= rem_s[k-1][i];
						quo_s[k][i] <= quo_s[k-1][i];
					end
				end
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			qv[i] = qneg_s[NS][i] ? -$signed(HW'(quo_s[NS][i])) : $signed(HW'(quo_s[NS][i]));
			hw[i] = HW'(p_s[NS][i]) + qv[i];
			vw[i] = hw[i] >>> FRAC_BITS;
			if (ax_s[NS] == vrns_pkg::AXIS_NONE) begin
				hit_o[i] = '0;
				vox_o[i] = '0;
			end else if (ax_s[NS] == vrns_pkg::axis_t'(2'(i))) begin
				// The crossed axis lands exactly on the plane.
				hit_o[i] = sat32(pl_s[NS][i] <<< FRAC_BITS);
				vox_o[i] = sat16(pl_s[NS][i] - (negd_s[NS][i] ? HW'(1) : HW'(0)));
			end else begin
				hit_o[i] = sat32(hw[i]);
				vox_o[i] = sat16(vw[i]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			voxel_x      <= vox_o[0];
			voxel_y      <= vox_o[1];
			voxel_z      <= vox_o[2];
			hit_x        <= hit_o[0];
			hit_y        <= hit_o[1];
			hit_z        <= hit_o[2];
			crossed_axis <= ax_s[NS];
		end
	end

endmodule

/* sv/voxel_ray_next_cell_step_top.sv */
// Top level of the voxel ray next-cell step block.
//
// One item on the request channel (req_valid, req_stall) carries a point and a
// direction in signed fixed point with FRAC_BITS fraction bits. One item comes
// back on the response channel (rsp_valid, rsp_stall) for each request: the
// voxel entered, the crossing point and the crossed axis (3 for a zero direction).
// A new item is accepted every cycle while req_stall is low. Four front stages
// classify the item, it passes the four-entry queue, and the back part runs it
// through the restoring divider, one quotient bit per stage, before the output
// register.
// When the receiver stalls, the output register holds its item and the back part
// freezes; the front keeps accepting until the queue fills, then raises req_stall.
// Reset empties all stages and the queue and sets step_bias to 655 (about 0.01).
// step_bias sits at APB byte address 0 and reads back there; write it only while
// no item is in flight.
module voxel_ray_next_cell_step_top #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic signed [31:0] dir_x,
	input  logic signed [31:0] dir_y,
	input  logic signed [31:0] dir_z,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic signed [15:0] voxel_x,
	output logic signed [15:0] voxel_y,
	output logic signed [15:0] voxel_z,
	output logic signed [31:0] hit_x,
	output logic signed [31:0] hit_y,
	output logic signed [31:0] hit_z,
	output logic [1:0]         crossed_axis,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	logic [vrns_pkg::BIAS_W-1:0] bias_q;
	logic sel_bias;

	vrns_pkg::push_t push;
	logic            push_full;
	logic            pop;
	logic            head_valid;
	vrns_pkg::step_t head;

	assign pready   = 1'b1;
	assign sel_bias = (paddr[2:2] == 1'(vrns_pkg::REG_STEP_BIAS));
	assign prdata   = sel_bias ? {16'd0, bias_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bias_q <= vrns_pkg::BIAS_RESET;
		end else if (psel && penable && pwrite && pready && sel_bias) begin
			bias_q <= pwdata[vrns_pkg::BIAS_W-1:0];
		end
	end

	vrns_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.pos_z     (pos_z),
		.dir_x     (dir_x),
		.dir_y     (dir_y),
		.dir_z     (dir_z),
		.step_bias (bias_q),
		.push      (push),
		.push_full (push_full)
	);

	vrns_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (push_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	vrns_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head         (head),
		.pop          (pop),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.voxel_x      (voxel_x),
		.voxel_y      (voxel_y),
		.voxel_z      (voxel_z),
		.hit_x        (hit_x),
		.hit_y        (hit_y),
		.hit_z        (hit_z),
		.crossed_axis (crossed_axis)
	);

endmodule

/* sv/vrns_chk.sv */
// Port-level checks for the voxel ray next-cell step block, bound to the top level.
module vrns_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               rsp_valid,
	input logic               rsp_stall,
	input logic signed [15:0] voxel_x,
	input logic signed [15:0] voxel_y,
	input logic signed [15:0] voxel_z,
	input logic signed [31:0] hit_x,
	input logic signed [31:0] hit_y,
	input logic signed [31:0] hit_z,
	input logic [1:0]         crossed_axis,
	input logic               psel,
	input logic               penable,
	input logic               pwrite,
	input logic [2:0]         paddr,
	input logic [31:0]        pwdata,
	input logic [31:0]        prdata
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid)
		else $error("response item dropped while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> $stable(voxel_x) && $stable(voxel_y) &&
		$stable(voxel_z) && $stable(hit_x) && $stable(hit_y) && $stable(hit_z) &&
		$stable(crossed_axis))
		else $error("stalled response item changed");

	a_zero_dir: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && crossed_axis == vrns_pkg::AXIS_NONE |->
		voxel_x == 16'sd0 && voxel_y == 16'sd0 && voxel_z == 16'sd0 &&
		hit_x == 32'sd0 && hit_y == 32'sd0 && hit_z == 32'sd0)
		else $error("zero direction item carries nonzero fields");

	a_bias_readback: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && paddr[2] == 1'b0) ##1
		(psel && !pwrite && paddr[2] == 1'b0) |->
		prdata[15:0] == $past(pwdata[15:0]))
		else $error("step_bias read back differs from the value written");

endmodule

bind voxel_ray_next_cell_step_top vrns_chk u_vrns_chk (.*);

/* tb/voxel_ray_next_cell_step_checker.sv */
// Checker for the voxel ray next-cell step block: tracks step_bias, predicts and compares items.
module voxel_ray_next_cell_step_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	input  logic               req_stall,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic signed [31:0] dir_x,
	input  logic signed [31:0] dir_y,
	input  logic signed [31:0] dir_z,
	input  logic               rsp_valid,
	input  logic               rsp_stall,
	input  logic signed [15:0] voxel_x,
	input  logic signed [15:0] voxel_y,
	input  logic signed [15:0] voxel_z,
	input  logic signed [31:0] hit_x,
	input  logic signed [31:0] hit_y,
	input  logic signed [31:0] hit_z,
	input  logic [1:0]         crossed_axis,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	input  logic               pready,
	output int                 mismatches,
	output int                 pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC = 16;

	typedef struct packed {
		logic [2:0][15:0]  vox;
		logic [2:0][31:0]  hit;
		vrns_pkg::axis_t   axis;
	} crossing_t;

	crossing_t expected_crossings[$];
	logic [vrns_pkg::BIAS_W-1:0] bias;

	function automatic longint mag(longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic longint clamp(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic crossing_t next_crossing(longint px, longint py, longint pz,
			longint dx, longint dy, longint dz, logic [vrns_pkg::BIAS_W-1:0] b);
		crossing_t r;
		longint p[3];
		longint d[3];
		longint pl[3];
		longint t[3];
		longint h;
		longint v;
		int best;
		d[0] = dx; d[1] = dy; d[2] = dz;
		p[0] = px; p[1] = py; p[2] = pz;
		best = -1;
		for (int a = 0; a < 3; a++) begin
			p[a] = p[a] + ((d[a] * longint'({1'b0, b})) >>> vrns_pkg::BIAS_W);
			pl[a] = (p[a] >>> FRAC) + (d[a] > 0 ? 1 : 0);
			t[a] = pl[a] * (64'sd1 << FRAC) - p[a];
		end
		// Zero-direction axes are skipped; strict compare keeps ties on the lower axis.
		for (int a = 0; a < 3; a++) begin
			if (d[a] != 0) begin
				if (best < 0 || mag(t[best]) * mag(d[a]) > mag(t[a]) * mag(d[best]))
					best = a;
			end
		end
		r = '0;
		if (best < 0) begin
			r.axis = vrns_pkg::AXIS_NONE;
			return r;
		end
		for (int a = 0; a < 3; a++) begin
			if (a == best) begin
				h = pl[a] * (64'sd1 << FRAC);
				v = pl[a] - (d[a] < 0 ? 1 : 0);
			end else begin
				h = p[a] + (d[a] * t[best]) / d[best];
				v = h >>> FRAC;
			end
			r.hit[a] = 32'(clamp(h, -(64'sd1 << 31), (64'sd1 << 31) - 1));
			r.vox[a] = 16'(clamp(v, -32768, 32767));
		end
		r.axis = vrns_pkg::axis_t'(best);
		return r;
	endfunction

	assign pending = expected_crossings.size();

	always @(posedge clk or negedge arst_n) begin
		crossing_t got;
		crossing_t want;
		if (!arst_n) begin
			bias <= vrns_pkg::BIAS_RESET;
			expected_crossings.delete();
			mismatches <= 0;
		end else begin
			if (psel && penable && pwrite && pready &&
					paddr == 3'(4 * vrns_pkg::REG_STEP_BIAS))
				bias <= pwdata[vrns_pkg::BIAS_W-1:0];
			if (req_valid && !req_stall)
				expected_crossings.push_back(next_crossing(pos_x, pos_y, pos_z,
					dir_x, dir_y, dir_z, bias));
			if (rsp_valid && !rsp_stall) begin
				got.vox = {voxel_z, voxel_y, voxel_x};
				got.hit = {hit_z, hit_y, hit_x};
				got.axis = vrns_pkg::axis_t'(crossed_axis);
				if (expected_crossings.size() == 0) begin
					if (mismatches < 10)
						$display("ERROR: unexpected item vox=%p hit=%p axis=%0d",
							got.vox, got.hit, got.axis);
					mismatches <= mismatches + 1;
				end else begin
					want = expected_crossings.pop_front();
					if (got !== want) begin
						if (mismatches < 10)
							$display("ERROR: exp vox=%p hit=%p axis=%0d got vox=%p hit=%p axis=%0d",
								want.vox, want.hit, want.axis,
								got.vox, got.hit, got.axis);
						mismatches <= mismatches + 1;
					end
				end
			end
		end
	end

endmodule

/* tb/voxel_ray_next_cell_step_top_tb.sv */
// Testbench top for the voxel ray next-cell step block: stimulus, register writes and verdict.
module voxel_ray_next_cell_step_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY = 40;
	localparam int CYCLE_LIMIT = 600000;

	logic clk = 0;
	logic arst_n = 0;
	logic req_valid = 0;
	logic req_stall;
	logic signed [31:0] pos_x = 0, pos_y = 0, pos_z = 0;
	logic signed [31:0] dir_x = 0, dir_y = 0, dir_z = 0;
	logic rsp_valid;
	logic rsp_stall = 0;
	logic signed [15:0] voxel_x, voxel_y, voxel_z;
	logic signed [31:0] hit_x, hit_y, hit_z;
	logic [1:0] crossed_axis;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [2:0] paddr = 0;
	logic [31:0] pwdata = 0;
	logic [31:0] prdata;
	logic pready;
	int mismatches, pending;
	int cycles = 0;
	bit quiet = 0;

	voxel_ray_next_cell_step_top DUT (.*);
	voxel_ray_next_cell_step_checker checker_i (.*);

	initial begin
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Receiver stalls in random bursts, none once the run goes quiet.
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			if (quiet || $urandom_range(0, 2) == 0) begin
				rsp_stall <= 0;
				n = $urandom_range(1, 30);
			end else begin
				rsp_stall <= 1;
				n = $urandom_range(1, 12);
			end
			repeat (n) @(posedge clk);
		end
	end

	task automatic reg_write(logic [2:0] addr, logic [31:0] data);
		psel <= 1; pwrite <= 1; penable <= 0; paddr <= addr; pwdata <= data;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		@(posedge clk);
	endtask

	task automatic send_step(logic signed [31:0] px, py, pz, dx, dy, dz);
		bit stalled;
		req_valid <= 1;
		pos_x <= px; pos_y <= py; pos_z <= pz;
		dir_x <= dx; dir_y <= dy; dir_z <= dz;
		do begin
			@(negedge clk);
			stalled = req_stall;
			@(posedge clk);
		end while (stalled);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			req_valid <= 0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	task automatic drain();
		req_valid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 9))
			0: return $urandom();
			1: return 32'sh7fffffff;
			2: return 32'sh80000000;
			3: return 0;
			4: return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'h0000}
				+ 32'($urandom_range(0, 65535));
			default: return 32'(int'($urandom_range(0, 40 * 65536)) - 20 * 65536);
		endcase
	endfunction

	function automatic logic [31:0] rand_dir();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return $urandom();
			2: return 32'sh7fffffff;
			3: return 32'sh80000000;
			4: return 32'(int'($urandom_range(0, 8)) - 4);
			default: return 32'(int'($urandom_range(0, 4 * 65536)) - 2 * 65536);
		endcase
	endfunction

	initial begin
		logic [31:0] biases[4];
		biases = '{32'd0, 32'hffff, 32'd0, 32'd655};
		biases[2] = $urandom_range(1, 65534);
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed items at the reset bias.
		send_step(0, 0, 0, 0, 0, 0);
		send_step(32'sh00018000, 32'sh00004000, 0, 32'sh00010000, 0, 0);
		send_step(32'sh00008000, 32'sh00008000, 32'sh00008000, 0, 32'shffff0000, 0);
		send_step(32'sh00008000, 32'sh00008000, 32'sh00008000, 0, 0, 32'sh00010000);
		send_step(32'sh00008000, 32'sh00008000, 32'sh00008000,
			32'sh00010000, 32'sh00010000, 32'sh00010000);
		send_step(32'sh00008000, 32'sh00008000, 32'sh00008000,
			32'shffff0000, 32'shffff0000, 32'shffff0000);
		send_step(32'sh00010000, 32'shfffe0000, 0, 32'shffff0000, 32'sh00000001, 0);
		send_step(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
			32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
		send_step(32'sh80000000, 32'sh80000000, 32'sh80000000,
			32'sh80000000, 32'sh80000000, 32'sh80000000);
		send_step(32'sh7fff0000, 0, 32'sh80000000, 32'sh00000001, 32'sh7fffffff, 0);
		send_step(0, 32'sh7fffffff, 0, 32'sh80000000, 32'sh00000001, 32'sh7fffffff);
		send_step(32'shffffffff, 32'sh00000001, 0, 0, 0, 32'shffffffff);
		send_step(32'sh12345678, 32'shedcba987, 32'sh0000ffff,
			32'sh00000003, 32'shfffffffd, 32'sh00000002);
		send_step(0, 0, 0, 32'sh80000000, 0, 0);
		drain();

		// Ignored register index.
		reg_write(3'd4, 32'hffffffff);
		for (int ph = 0; ph < 4; ph++) begin
			reg_write(3'(4 * vrns_pkg::REG_STEP_BIAS), biases[ph]);
			for (int i = 0; i < 250; i++) begin
				if (ph == 3 && i >= 100)
					quiet = 1;
				send_step(rand_coord(), rand_coord(), rand_coord(),
					rand_dir(), rand_dir(), rand_dir());
			end
			drain();
		end

		if (mismatches == 0 && pending == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

/* voxel_ray_next_cell_step_top.f */
sv/vrns_pkg.sv
sv/vrns_front.sv
sv/vrns_queue.sv
sv/vrns_back.sv
sv/voxel_ray_next_cell_step_top.sv
sv/vrns_chk.sv
tb/voxel_ray_next_cell_step_checker.sv
tb/voxel_ray_next_cell_step_top_tb.sv
